// ===== hdl/u128div_pkg.sv =====
// Shared types and constants for the unsigned 128-bit divider.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u128div_pkg;

  localparam int unsigned WordBits  = 64;
  localparam int unsigned WideBits  = 2 * WordBits;
  localparam int unsigned StepCntW  = $clog2(WideBits);
  localparam int unsigned TdataBits = 4 * WordBits;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // take operands from the input beat
    logic step;     // one restoring shift-subtract step
    logic capture;  // move the finished result into the output register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic den_zero; // divisor on the input beat is zero
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/u128div_datapath.sv =====
// Datapath of the 128-bit divider: operand registers, restoring step, result register.
// Depends on u128div_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u128div_datapath (
  input  wire                                     clk_i,
  input  wire  [u128div_pkg::TdataBits-1:0]       in_data_i,
  input  wire  u128div_pkg::dp_cmd_t              cmd_i,
  output u128div_pkg::dp_status_t                 status_o,
  output logic [u128div_pkg::TdataBits-1:0]       res_data_o,
  output logic                                    res_dbz_o
);

  localparam int unsigned W = u128div_pkg::WideBits;
  localparam int unsigned H = u128div_pkg::WordBits;

  // num_q holds the dividend and fills with quotient bits from the bottom
  logic [W-1:0] num_q, num_d;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] den_q, den_d;
  logic         dbz_q, dbz_d;
  logic [u128div_pkg::TdataBits-1:0] res_q, res_d;
  logic         res_dbz_q, res_dbz_d;

  logic [W-1:0] in_num, in_den;
  logic [W:0]   shifted, diff;
  logic         take;
  logic [W-1:0] quo_out, rem_out;

  // Unpack input beat: high half sits in the lower tdata bits
  assign in_num = {in_data_i[H-1:0], in_data_i[2*H-1:H]};
  assign in_den = {in_data_i[3*H-1:2*H], in_data_i[4*H-1:3*H]};
  assign status_o.den_zero = (in_den == '0);

  // Restoring step: shift in next dividend bit, subtract if it fits
  assign shifted = {rem_q, num_q[W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign take    = ~diff[W];

  // Zero divisor: quotient zero, remainder is the untouched dividend
  assign quo_out = dbz_q ? '0 : num_q;
  assign rem_out = dbz_q ? num_q : rem_q;

  always_comb begin
    num_d     = num_q;
    rem_d     = rem_q;
    den_d     = den_q;
    dbz_d     = dbz_q;
    res_d     = res_q;
    res_dbz_d = res_dbz_q;
    if (cmd_i.load) begin
      num_d = in_num;
      rem_d = '0;
      den_d = in_den;
      dbz_d = status_o.den_zero;
    end else if (cmd_i.step) begin
      num_d = {num_q[W-2:0], take};
      rem_d = take ? diff[W-1:0] : shifted[W-1:0];
    end
    if (cmd_i.capture) begin
      res_d     = {rem_out[H-1:0], rem_out[W-1:H], quo_out[H-1:0], quo_out[W-1:H]};
      res_dbz_d = dbz_q;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    num_q     <= num_d;
    rem_q     <= rem_d;
    den_q     <= den_d;
    dbz_q     <= dbz_d;
    res_q     <= res_d;
    res_dbz_q <= res_dbz_d;
  end

  assign res_data_o = res_q;
  assign res_dbz_o  = res_dbz_q;

endmodule

`default_nettype wire

// ===== hdl/u128div_ctrl.sv =====
// Controller of the 128-bit divider: handshakes, step counter and sequencing.
// Depends on u128div_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u128div_ctrl (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  input  wire  u128div_pkg::dp_status_t status_i,
  output u128div_pkg::dp_cmd_t          cmd_o
);

  localparam logic [u128div_pkg::StepCntW-1:0] LastStep = '1;

  u128div_pkg::state_e state_q, state_d;
  logic [u128div_pkg::StepCntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic in_beat, out_free;

  assign in_ready_o  = (state_q == u128div_pkg::ST_IDLE);
  assign in_beat     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o.load    = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.capture = 1'b0;
    out_valid_d   = out_valid_q & ~out_ready_i;
    unique case (state_q)
      u128div_pkg::ST_IDLE: begin
        if (in_beat) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = status_i.den_zero ? u128div_pkg::ST_HOLD : u128div_pkg::ST_RUN;
        end
      end
      u128div_pkg::ST_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          state_d = u128div_pkg::ST_HOLD;
        end
      end
      u128div_pkg::ST_HOLD: begin
        if (out_free) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = u128div_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = u128div_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= u128div_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/unsigned_128bit_divider_core.sv =====
// Unsigned 128-bit divider, restoring shift-subtract, one quotient bit per clock.
// An accepted beat is loaded into the operand registers, then 128 steps run through
// a single 129-bit subtractor, and the result moves into the output register once
// the output is free, one division at a time.
// A zero divisor skips the steps, sets tuser, returns quotient zero
// and the dividend as remainder. The result register lets a new operand beat
// be taken while an earlier result is still waiting on the output.
// Depends on u128div_pkg, u128div_ctrl and u128div_datapath.
`timescale 1ns / 1ps
`default_nettype none

module unsigned_128bit_divider_core (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata from bit 0: dividend_hi, dividend_lo, divisor_hi, divisor_lo (64 each)
  input  wire  [u128div_pkg::TdataBits-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire                                    m_axis_tready,
  // tdata from bit 0: quotient_hi, quotient_lo, remainder_hi, remainder_lo (64 each)
  output logic [u128div_pkg::TdataBits-1:0]      m_axis_tdata,
  // tuser bit 0: divide_by_zero
  output logic                                   m_axis_tuser
);

  u128div_pkg::dp_cmd_t    cmd;
  u128div_pkg::dp_status_t status;

  // Sequencing and handshakes
  u128div_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Operands, step logic and result register
  u128div_datapath u_datapath (
    .clk_i      (clk_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .res_data_o (m_axis_tdata),
    .res_dbz_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire
